[rtl/mspg_pkg.sv]
`default_nettype none

package mspg_pkg;

  // item kinds
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_BLOCK   = 2'd1;
  localparam logic [1:0] FUNC_SEGMENT = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_INVERT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNIT  = 2'd1;

  localparam logic [30:0] TIME_UNIT_RESET = 31'd10000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  block_slot;
    logic [30:0] steps_x;
    logic [30:0] steps_y;
    logic [30:0] steps_z;
    logic [2:0]  dir_bits;
    logic [30:0] event_count;
    logic [7:0]  seg_steps;
    logic [30:0] phase_limit;
    logic [30:0] rate_per_tick;
  } item_t;

  typedef struct packed {
    logic               pins_update;
    logic [5:0]         pin_word;
    logic               cycle_stop;
    logic               accepted;
    logic [2:0]         ring_level;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } result_t;

endpackage

`default_nettype wire

[rtl/mspg_axis.sv]
`default_nettype none

// One Bresenham axis: error term update and position follow-up.
module mspg_axis
  import mspg_pkg::*;
(
  input  wire logic               fire,
  input  wire logic [31:0]        acc_base,
  input  wire logic [30:0]        steps,
  input  wire logic [30:0]        events,
  input  wire logic               neg,
  input  wire logic signed [31:0] pos,
  output logic [31:0]             acc_next,
  output logic signed [31:0]      pos_next,
  output logic                    step
);

  logic [31:0] acc_sub;

  assign acc_sub = acc_base - {1'b0, steps};
  assign step    = fire & acc_sub[31];

  always_comb begin
    if (!fire) begin
      acc_next = acc_base;
    end else if (acc_sub[31]) begin
      acc_next = acc_sub + {1'b0, events};
    end else begin
      acc_next = acc_sub;
    end
  end

  always_comb begin
    if (!step) begin
      pos_next = pos;
    end else if (neg) begin
      pos_next = pos - 32'sd1;
    end else begin
      pos_next = pos + 32'sd1;
    end
  end

endmodule

`default_nettype wire

[rtl/multi_axis_step_pulse_generator.sv]
// Three-axis step pulse generator (inverse-time rate, Bresenham tracing).
// Input channel item / item_valid / item_stall carries one item per accept:
// a timer tick, a block-table write or a segment push (see func).
// Output channel result / result_valid / result_stall returns exactly one
// result item per input item, in order: pin word to drive on this tick,
// cycle stop flag, push acceptance, ring fill level and the three positions.
// Config channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
// pin_invert (index 0) and time_unit (index 1); cfg_ready is always high,
// other indexes are ignored. Write config only while the block is idle.
// An accepted item is held in the input register, then processed into the
// result register, from which its result shows. Throughput: one item per
// cycle while the receiver does not stall; the whole tick update (ring
// read, block lookup, time counter subtract/reload, three axis error
// terms) is one register-to-register pass.
// Receiver stall: the result register holds; the input register still
// takes one more item, after which item_stall goes high until the result
// is taken.
// Reset (rst, synchronous): ring empty, counters, positions and pending
// pins cleared, pin_invert 0, time_unit 10000000. Block table and ring
// contents are not cleared.
`default_nettype none

module multi_axis_step_pulse_generator
  import mspg_pkg::*;
#(
  parameter int RING_SLOTS  = 6,
  parameter int BLOCK_SLOTS = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [30:0]          cfg_data
);

  localparam int RAW    = $clog2(RING_SLOTS);
  localparam int BLK_AW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

  // config registers
  logic [5:0]  pin_invert;
  logic [30:0] time_unit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_invert <= '0;
      time_unit  <= TIME_UNIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PIN_INVERT) begin
        pin_invert <= cfg_data[5:0];
      end
      if (cfg_index == CFG_TIME_UNIT) begin
        time_unit <= cfg_data;
      end
    end
  end

  // input register and handshake
  item_t item_q;
  logic  item_q_valid;
  logic  advance;

  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  // block table, one read port at the effective slot
  logic [30:0] blk_steps_x [BLOCK_SLOTS];
  logic [30:0] blk_steps_y [BLOCK_SLOTS];
  logic [30:0] blk_steps_z [BLOCK_SLOTS];
  logic [2:0]  blk_dirs    [BLOCK_SLOTS];
  logic [30:0] blk_events  [BLOCK_SLOTS];

  // segment ring, written at head, read at tail
  logic [7:0]  seg_count_store [RING_SLOTS];
  logic [2:0]  seg_slot_store  [RING_SLOTS];
  logic [30:0] seg_phase_store [RING_SLOTS];
  logic [30:0] seg_rate_store  [RING_SLOTS];

  // execution state
  logic [RAW-1:0]     ring_head, ring_head_next;
  logic [RAW-1:0]     ring_tail, ring_tail_next;
  logic               seg_active, seg_active_next;
  logic [7:0]         steps_left, steps_left_next;
  logic [2:0]         cur_slot, cur_slot_next;
  logic [31:0]        acc_x, acc_x_next;
  logic [31:0]        acc_y, acc_y_next;
  logic [31:0]        acc_z, acc_z_next;
  logic [31:0]        time_acc, time_acc_next;
  logic [5:0]         pending_pins, pending_pins_next;
  logic               pending_flag, pending_flag_next;
  logic signed [31:0] pos_x, pos_x_next;
  logic signed [31:0] pos_y, pos_y_next;
  logic signed [31:0] pos_z, pos_z_next;

  // ring pointers
  logic [RAW-1:0] head_inc, tail_inc;
  logic           ring_empty, ring_full;

  assign head_inc   = (ring_head == RAW'(RING_SLOTS - 1)) ? '0 : ring_head + 1'b1;
  assign tail_inc   = (ring_tail == RAW'(RING_SLOTS - 1)) ? '0 : ring_tail + 1'b1;
  assign ring_empty = (ring_head == ring_tail);
  assign ring_full  = (head_inc == ring_tail);

  // tick datapath
  logic              is_tick, loading, new_blk, run, fire, retire;
  logic [2:0]        eff_slot;
  logic              slot_ok;
  logic [BLK_AW-1:0] rd_idx;
  logic [30:0]       rd_steps_x, rd_steps_y, rd_steps_z, rd_events;
  logic [2:0]        rd_dirs;
  logic [7:0]        steps_base, steps_after;
  logic [31:0]       acc_init, acc_x_base, acc_y_base, acc_z_base;
  logic [31:0]       time_base, time_dec, time_new;
  logic [2:0]        step_bits;
  logic [31:0]       axs_acc_x, axs_acc_y, axs_acc_z;
  logic signed [31:0] axs_pos_x, axs_pos_y, axs_pos_z;

  assign is_tick  = (item_q.func == FUNC_TICK);
  assign loading  = !seg_active && !ring_empty;
  assign run      = seg_active || loading;
  assign eff_slot = loading ? seg_slot_store[ring_tail] : cur_slot;
  assign new_blk  = loading && (cur_slot != seg_slot_store[ring_tail]);

  // slots past the table read as all-zero block data
  assign slot_ok    = (32'(eff_slot) < BLOCK_SLOTS);
  assign rd_idx     = BLK_AW'(eff_slot);
  assign rd_steps_x = slot_ok ? blk_steps_x[rd_idx] : '0;
  assign rd_steps_y = slot_ok ? blk_steps_y[rd_idx] : '0;
  assign rd_steps_z = slot_ok ? blk_steps_z[rd_idx] : '0;
  assign rd_dirs    = slot_ok ? blk_dirs[rd_idx]    : '0;
  assign rd_events  = slot_ok ? blk_events[rd_idx]  : '0;

  assign steps_base = loading ? seg_count_store[ring_tail] : steps_left;
  assign acc_init   = {2'b00, rd_events[30:1]};
  assign acc_x_base = new_blk ? acc_init : acc_x;
  assign acc_y_base = new_blk ? acc_init : acc_y;
  assign acc_z_base = new_blk ? acc_init : acc_z;
  assign time_base  = new_blk ? {1'b0, time_unit} : time_acc;

  assign time_dec    = time_base - {1'b0, seg_rate_store[ring_tail]};
  assign fire        = run && time_dec[31] && (steps_base != '0);
  assign time_new    = fire ? time_dec + {1'b0, time_unit} : time_dec;
  assign steps_after = fire ? steps_base - 8'd1 : steps_base;
  assign retire      = run && (steps_after == '0) &&
                       (time_new[31] || ({1'b0, seg_phase_store[ring_tail]} > time_new));

  mspg_axis u_axis_x (
    .fire     (fire),
    .acc_base (acc_x_base),
    .steps    (rd_steps_x),
    .events   (rd_events),
    .neg      (rd_dirs[0]),
    .pos      (pos_x),
    .acc_next (axs_acc_x),
    .pos_next (axs_pos_x),
    .step     (step_bits[0])
  );

  mspg_axis u_axis_y (
    .fire     (fire),
    .acc_base (acc_y_base),
    .steps    (rd_steps_y),
    .events   (rd_events),
    .neg      (rd_dirs[1]),
    .pos      (pos_y),
    .acc_next (axs_acc_y),
    .pos_next (axs_pos_y),
    .step     (step_bits[1])
  );

  mspg_axis u_axis_z (
    .fire     (fire),
    .acc_base (acc_z_base),
    .steps    (rd_steps_z),
    .events   (rd_events),
    .neg      (rd_dirs[2]),
    .pos      (pos_z),
    .acc_next (axs_acc_z),
    .pos_next (axs_pos_z),
    .step     (step_bits[2])
  );

  // next state and result
  result_t res;
  logic    wr_block, wr_segment;
  logic [RAW:0] level;

  always_comb begin
    ring_head_next    = ring_head;
    ring_tail_next    = ring_tail;
    seg_active_next   = seg_active;
    steps_left_next   = steps_left;
    cur_slot_next     = cur_slot;
    acc_x_next        = acc_x;
    acc_y_next        = acc_y;
    acc_z_next        = acc_z;
    time_acc_next     = time_acc;
    pending_pins_next = pending_pins;
    pending_flag_next = pending_flag;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    pos_z_next        = pos_z;
    wr_block          = 1'b0;
    wr_segment        = 1'b0;
    res               = '0;
    res.accepted      = 1'b1;

    unique case (item_q.func)
      FUNC_TICK: begin
        // drive what the previous tick queued
        if (pending_flag) begin
          res.pins_update = 1'b1;
          res.pin_word    = pending_pins;
        end
        pending_flag_next = 1'b0;
        if (!run) begin
          res.cycle_stop = 1'b1;
        end else begin
          cur_slot_next = eff_slot;
          acc_x_next    = axs_acc_x;
          acc_y_next    = axs_acc_y;
          acc_z_next    = axs_acc_z;
          time_acc_next = time_new;
          pos_x_next    = axs_pos_x;
          pos_y_next    = axs_pos_y;
          pos_z_next    = axs_pos_z;
          steps_left_next = steps_after;
          if (fire) begin
            pending_pins_next = {rd_dirs, step_bits} ^ pin_invert;
            pending_flag_next = 1'b1;
          end else if (new_blk) begin
            // direction setup ahead of the first step of a new block
            pending_pins_next = {rd_dirs, 3'b000} ^ pin_invert;
            pending_flag_next = 1'b1;
          end
          if (retire) begin
            seg_active_next = 1'b0;
            ring_tail_next  = tail_inc;
          end else begin
            seg_active_next = 1'b1;
          end
        end
      end
      FUNC_BLOCK: begin
        wr_block = (32'(item_q.block_slot) < BLOCK_SLOTS);
      end
      FUNC_SEGMENT: begin
        if (ring_full) begin
          res.accepted = 1'b0;
        end else begin
          wr_segment     = 1'b1;
          ring_head_next = head_inc;
        end
      end
      default: begin
      end
    endcase

    if (ring_head_next >= ring_tail_next) begin
      level = {1'b0, ring_head_next} - {1'b0, ring_tail_next};
    end else begin
      level = {1'b0, ring_head_next} + (RAW + 1)'(RING_SLOTS) - {1'b0, ring_tail_next};
    end
    res.ring_level = 3'(level);
    res.pos_x      = pos_x_next;
    res.pos_y      = pos_y_next;
    res.pos_z      = pos_z_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head    <= '0;
      ring_tail    <= '0;
      seg_active   <= 1'b0;
      steps_left   <= '0;
      cur_slot     <= '0;
      acc_x        <= '0;
      acc_y        <= '0;
      acc_z        <= '0;
      time_acc     <= '0;
      pending_pins <= '0;
      pending_flag <= 1'b0;
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
    end else if (advance) begin
      ring_head    <= ring_head_next;
      ring_tail    <= ring_tail_next;
      seg_active   <= seg_active_next;
      steps_left   <= steps_left_next;
      cur_slot     <= cur_slot_next;
      acc_x        <= acc_x_next;
      acc_y        <= acc_y_next;
      acc_z        <= acc_z_next;
      time_acc     <= time_acc_next;
      pending_pins <= pending_pins_next;
      pending_flag <= pending_flag_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      pos_z        <= pos_z_next;
    end
  end

  // table and ring storage, no reset
  always_ff @(posedge clk) begin
    if (advance && wr_block) begin
      blk_steps_x[BLK_AW'(item_q.block_slot)] <= item_q.steps_x;
      blk_steps_y[BLK_AW'(item_q.block_slot)] <= item_q.steps_y;
      blk_steps_z[BLK_AW'(item_q.block_slot)] <= item_q.steps_z;
      blk_dirs[BLK_AW'(item_q.block_slot)]    <= item_q.dir_bits;
      blk_events[BLK_AW'(item_q.block_slot)]  <= item_q.event_count;
    end
    if (advance && wr_segment) begin
      seg_count_store[ring_head] <= item_q.seg_steps;
      seg_slot_store[ring_head]  <= item_q.block_slot;
      seg_phase_store[ring_head] <= item_q.phase_limit;
      seg_rate_store[ring_head]  <= item_q.rate_per_tick;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  // an active segment always sits in the ring
  a_active_in_ring: assert property (@(posedge clk) disable iff (rst)
    seg_active |-> !ring_empty)
    else $error("active segment with empty ring");

  // pending pins are only queued by a processed tick
  a_pending_src: assert property (@(posedge clk) disable iff (rst)
    $rose(pending_flag) |-> $past(advance && item_q.func == FUNC_TICK))
    else $error("pending pins set outside a tick");

  // the tail moves only on a processed tick
  a_tail_src: assert property (@(posedge clk) disable iff (rst)
    (ring_tail != $past(ring_tail)) |-> $past(advance && item_q.func == FUNC_TICK))
    else $error("ring tail moved outside a tick");

  // an idle tick on an empty ring reports cycle stop
  a_stop: assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick && !seg_active && ring_empty) |=> result.cycle_stop)
    else $error("missing cycle stop");

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench;
  import mspg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 6;   // one slot always kept free
  localparam int TABLE_DEPTH = 5;
  localparam logic [1:0] FUNC_SPARE = 2'd3;   // undefined kind, block ignores it
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [30:0]          cfg_data = '0;

  multi_axis_step_pulse_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Machine model: our own copy of the block state and registers
  // ---------------------------------------------------------------------------
  bit [30:0] table_sx [TABLE_DEPTH];
  bit [30:0] table_sy [TABLE_DEPTH];
  bit [30:0] table_sz [TABLE_DEPTH];
  bit [2:0]  table_dir [TABLE_DEPTH];
  bit [30:0] table_events [TABLE_DEPTH];
  bit [7:0]  ring_steps [RING_DEPTH];
  bit [2:0]  ring_block [RING_DEPTH];
  bit [31:0] ring_phase [RING_DEPTH];
  bit [31:0] ring_rate [RING_DEPTH];
  int        wr_ptr, rd_ptr;
  bit        running;
  bit [7:0]  events_left;
  bit [2:0]  live_block;
  bit [31:0] trace_err [3];
  bit [31:0] clock_acc;
  bit [5:0]  armed_pins;
  bit        pins_armed;
  bit [31:0] axis_pos [3];
  bit [5:0]  mask_cfg;
  bit [31:0] unit_cfg;

  // run statistics for the closing summary
  int refused_pushes, stop_ticks, fired_steps, moves_sent;

  result_t due_reports [$];   // expected result per accepted item, oldest first
  int      error_count;
  int      send_idle_pct, stall_pct;
  bit      long_segment_done;

  function automatic int ring_fill();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  // Apply one item to the model, return what the block must report for it.
  function automatic result_t advance_machine(input item_t it);
    result_t   r;
    bit [2:0]  s;
    bit        live, run;
    bit [31:0] ev;
    bit [31:0] st [3];
    bit [2:0]  dirs;
    bit [5:0]  bits;
    r = '0;
    r.accepted = 1'b1;
    s = it.block_slot;
    case (it.func)
      FUNC_BLOCK: begin
        if (s < TABLE_DEPTH) begin
          table_sx[s] = it.steps_x;
          table_sy[s] = it.steps_y;
          table_sz[s] = it.steps_z;
          table_dir[s] = it.dir_bits;
          table_events[s] = it.event_count;
        end
      end
      FUNC_SEGMENT: begin
        if ((wr_ptr + 1) % RING_DEPTH == rd_ptr) begin
          r.accepted = 1'b0;
          refused_pushes++;
        end else begin
          ring_steps[wr_ptr] = it.seg_steps;
          ring_block[wr_ptr] = s;
          ring_phase[wr_ptr] = {1'b0, it.phase_limit};
          ring_rate[wr_ptr] = {1'b0, it.rate_per_tick};
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        end
      end
      FUNC_TICK: begin
        run = 1'b1;
        // last tick's pin word goes out first
        if (pins_armed) begin
          pins_armed = 1'b0;
          r.pins_update = 1'b1;
          r.pin_word = armed_pins;
        end
        if (!running) begin
          if (wr_ptr != rd_ptr) begin
            running = 1'b1;
            events_left = ring_steps[rd_ptr];
            // new block: restart the tracers and queue its direction pins
            if (live_block != ring_block[rd_ptr]) begin
              live_block = ring_block[rd_ptr];
              live = live_block < TABLE_DEPTH;
              dirs = live ? table_dir[live_block] : 3'd0;
              ev = live ? {1'b0, table_events[live_block]} : 32'd0;
              armed_pins = {dirs, 3'b000} ^ mask_cfg;
              pins_armed = 1'b1;
              for (int a = 0; a < 3; a++) trace_err[a] = ev >> 1;
              clock_acc = unit_cfg;
            end
          end else begin
            r.cycle_stop = 1'b1;
            stop_ticks++;
            run = 1'b0;
          end
        end
        if (run) begin
          clock_acc -= ring_rate[rd_ptr];
          if (clock_acc[31] && events_left != 0) begin
            live = live_block < TABLE_DEPTH;
            dirs = live ? table_dir[live_block] : 3'd0;
            ev = live ? {1'b0, table_events[live_block]} : 32'd0;
            st[0] = live ? {1'b0, table_sx[live_block]} : 32'd0;
            st[1] = live ? {1'b0, table_sy[live_block]} : 32'd0;
            st[2] = live ? {1'b0, table_sz[live_block]} : 32'd0;
            clock_acc += unit_cfg;
            events_left--;
            fired_steps++;
            bits = {dirs, 3'b000};
            for (int a = 0; a < 3; a++) begin
              trace_err[a] -= st[a];
              if (trace_err[a][31]) begin
                trace_err[a] += ev;
                if (dirs[a]) axis_pos[a] -= 1;
                else axis_pos[a] += 1;
                bits[a] = 1'b1;
              end
            end
            armed_pins = bits ^ mask_cfg;
            pins_armed = 1'b1;
          end
          // retire once steps are spent and the phase point is passed
          if (events_left == 0 && (clock_acc[31] || ring_phase[rd_ptr] > clock_acc)) begin
            running = 1'b0;
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          end
        end
      end
      default: ;
    endcase
    r.ring_level = 3'(ring_fill());
    r.pos_x = axis_pos[0];
    r.pos_y = axis_pos[1];
    r.pos_z = axis_pos[2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders; fields the kind does not use carry random junk
  // ---------------------------------------------------------------------------
  function automatic item_t junk_item();
    item_t it;
    it.func = FUNC_TICK;
    it.block_slot = 3'($urandom);
    it.steps_x = 31'($urandom);
    it.steps_y = 31'($urandom);
    it.steps_z = 31'($urandom);
    it.dir_bits = 3'($urandom);
    it.event_count = 31'($urandom);
    it.seg_steps = 8'($urandom);
    it.phase_limit = 31'($urandom);
    it.rate_per_tick = 31'($urandom);
    return it;
  endfunction

  function automatic item_t block_item(input bit [2:0] slot, input bit [30:0] sx, sy, sz,
                                       input bit [2:0] dirs, input bit [30:0] ev);
    item_t it;
    it = junk_item();
    it.func = FUNC_BLOCK;
    it.block_slot = slot;
    it.steps_x = sx;
    it.steps_y = sy;
    it.steps_z = sz;
    it.dir_bits = dirs;
    it.event_count = ev;
    return it;
  endfunction

  function automatic item_t segment_item(input bit [2:0] slot, input bit [7:0] n,
                                         input bit [30:0] phase, rate);
    item_t it;
    it = junk_item();
    it.func = FUNC_SEGMENT;
    it.block_slot = slot;
    it.seg_steps = n;
    it.phase_limit = phase;
    it.rate_per_tick = rate;
    return it;
  endfunction

  // Rate near the time unit so steps fire every few ticks; now and then anything.
  function automatic bit [30:0] pick_rate();
    bit [31:0] hi;
    case ($urandom_range(9))
      0: return 31'($urandom_range(MAX31, 1));
      1, 2: begin
        hi = (unit_cfg > {1'b0, MAX31} / 2) ? {1'b0, MAX31} : unit_cfg * 2;
        return 31'($urandom_range(hi, unit_cfg));
      end
      default: return 31'($urandom_range(unit_cfg, (unit_cfg / 4 > 0) ? unit_cfg / 4 : 1));
    endcase
  endfunction

  function automatic bit [30:0] pick_phase();
    if ($urandom_range(4) == 0) return 31'($urandom);
    return 31'($urandom_range(unit_cfg, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    due_reports.push_back(advance_machine(it));
    if (!(it.func == FUNC_SPARE || (it.func == FUNC_BLOCK && it.block_slot >= TABLE_DEPTH)))
      moves_sent++;
  endtask

  task automatic send_tick();
    send_item(junk_item());
  endtask

  // ticks until the ring empties or the cap is hit
  task automatic run_ticks(input int cap);
    int n;
    n = 0;
    while (ring_fill() != 0 && n < cap) begin
      send_tick();
      n++;
    end
  endtask

  // drop valid and let every expected result come back
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PIN_INVERT) mask_cfg = data[5:0];
    else if (idx == CFG_TIME_UNIT) unit_cfg = {1'b0, data};
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random receiver stalls, decided on the falling edge
  always @(negedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Checking: outputs sampled on the rising edge
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_reports.size() == 0) begin
        report_mismatch("result with no item outstanding", result.pos_x, 32'd0);
      end else begin
        want = due_reports.pop_front();
        if (result.pins_update !== want.pins_update)
          report_mismatch("pins_update", 32'(result.pins_update), 32'(want.pins_update));
        if (result.pin_word !== want.pin_word)
          report_mismatch("pin_word", 32'(result.pin_word), 32'(want.pin_word));
        if (result.cycle_stop !== want.cycle_stop)
          report_mismatch("cycle_stop", 32'(result.cycle_stop), 32'(want.cycle_stop));
        if (result.accepted !== want.accepted)
          report_mismatch("accepted", 32'(result.accepted), 32'(want.accepted));
        if (result.ring_level !== want.ring_level)
          report_mismatch("ring_level", 32'(result.ring_level), 32'(want.ring_level));
        if (result.pos_x !== want.pos_x) report_mismatch("pos_x", result.pos_x, want.pos_x);
        if (result.pos_y !== want.pos_y) report_mismatch("pos_y", result.pos_y, want.pos_y);
        if (result.pos_z !== want.pos_z) report_mismatch("pos_z", result.pos_z, want.pos_z);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every table slot before any segment can read one; extremes on slot 4.
  task automatic test_block_table();
    send_item(block_item(3'd0, 31'd3, 31'd2, 31'd1, 3'd0, 31'd3));
    send_item(block_item(3'd1, 31'd5, 31'd0, 31'd5, 3'd5, 31'd5));
    send_item(block_item(3'd2, 31'd1, 31'd7, 31'd4, 3'd2, 31'd7));
    send_item(block_item(3'd3, 31'd0, 31'd0, 31'd0, 3'd6, 31'd0));
    send_item(block_item(3'd4, MAX31, MAX31, MAX31, 3'd7, MAX31));
    // out-of-range slot is dropped, unknown kind does nothing
    send_item(block_item(3'd7, 31'd9, 31'd9, 31'd9, 3'd1, 31'd9));
    begin
      item_t spare;
      spare = junk_item();
      spare.func = FUNC_SPARE;
      send_item(spare);
    end
  endtask

  // Empty ring stops; a first segment on slot zero keeps the reset counters.
  task automatic test_first_segment();
    send_tick();
    send_item(segment_item(3'd0, 8'd2, 31'd0, unit_cfg[30:0]));
    repeat (3) send_tick();
  endtask

  // Fill the ring to refusal with one of each odd segment, then drain a bit.
  task automatic test_ring_limits();
    send_item(segment_item(3'd4, 8'd1, 31'd0, MAX31));            // biggest block, max rate
    send_item(segment_item(3'd6, 8'd2, 31'd0, unit_cfg[30:0]));   // slot past the table
    send_item(segment_item(3'd1, 8'd0, MAX31, 31'd0));            // no steps, zero rate
    send_item(segment_item(3'd1, 8'd1, 31'd0, 31'(unit_cfg / 2))); // same block again
    send_item(segment_item(3'd3, 8'd3, MAX31, 31'(unit_cfg * 2)));
    send_item(segment_item(3'd2, 8'd255, 31'd0, MAX31));          // ring full: refused
    run_ticks(10);
  endtask

  // One random stretch under the given registers and idling pattern.
  task automatic run_motion_phase(input bit [5:0] mask, input bit [30:0] tu,
                                  input int send_pct, input int stl_pct, input int count);
    int target, k;
    bit [2:0] slot;
    bit [30:0] ev;
    item_t it;
    wait_idle();
    write_register(CFG_PIN_INVERT, {25'd0, mask});
    write_register(CFG_TIME_UNIT, tu);
    send_idle_pct = send_pct;
    stall_pct = stl_pct;
    target = moves_sent + count;
    while (moves_sent < target) begin
      if ($urandom_range(99) < 70) begin
        // a well-formed move: maybe a fresh block, a few segments, then ticks
        slot = 3'($urandom_range(TABLE_DEPTH - 1));
        if ($urandom_range(2) != 0) begin
          ev = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40, 1));
          send_item(block_item(slot, 31'($urandom_range(ev)), 31'($urandom_range(ev)),
                               31'($urandom_range(ev)), 3'($urandom), ev));
        end
        k = $urandom_range(3, 1);
        repeat (k) send_item(segment_item(slot, 8'($urandom_range(6)), pick_phase(),
                                          pick_rate()));
        run_ticks($urandom_range(40, 3));
      end else begin
        case ($urandom_range(20))
          0, 1, 2: begin
            it = junk_item();
            it.func = FUNC_SPARE;
            send_item(it);
          end
          3, 4, 5: send_item(block_item(3'($urandom_range(7, TABLE_DEPTH)), 31'($urandom),
                                        31'($urandom), 31'($urandom), 3'($urandom),
                                        31'($urandom)));
          6, 7: send_item(block_item(3'($urandom_range(TABLE_DEPTH - 1)), 31'($urandom),
                                     31'($urandom), 31'($urandom), 3'($urandom),
                                     31'($urandom)));
          8, 9, 10, 11:
            send_item(segment_item(3'($urandom), 8'($urandom_range(10)), 31'($urandom),
                                   31'($urandom_range(MAX31, 1))));
          12, 13, 14: begin
            repeat ($urandom_range(6, 3))
              send_item(segment_item(3'($urandom_range(7)), 8'($urandom_range(4)),
                                     pick_phase(), pick_rate()));
          end
          20: begin
            if (!long_segment_done) begin
              long_segment_done = 1'b1;
              send_item(segment_item(3'($urandom_range(TABLE_DEPTH - 1)), 8'd255, 31'd0,
                                     unit_cfg[30:0]));
            end
          end
          default: repeat ($urandom_range(6, 1)) send_tick();
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mask_cfg = '0;
    unit_cfg = {1'b0, TIME_UNIT_RESET};
    wr_ptr = 0;
    rd_ptr = 0;
    running = 1'b0;
    events_left = '0;
    live_block = '0;
    clock_acc = '0;
    armed_pins = '0;
    pins_armed = 1'b0;
    for (int a = 0; a < 3; a++) begin
      trace_err[a] = '0;
      axis_pos[a] = '0;
    end
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    long_segment_done = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, registers at reset values
    test_block_table();
    test_first_segment();
    test_ring_limits();

    // random part: register extremes and every idling mix
    run_motion_phase(6'h3F, 31'd1000, 0, 0, 170);
    run_motion_phase(6'h00, 31'd1, 51, 0, 170);
    run_motion_phase(6'h15, MAX31, 0, 51, 170);
    run_motion_phase(6'($urandom), 31'd5000, 37, 37, 170);
    run_motion_phase(6'h2A, TIME_UNIT_RESET, 0, 0, 170);

    wait_idle();
    $display("covered %0d items: %0d step events, %0d stop ticks, %0d refused pushes",
             moves_sent, fired_steps, stop_ticks, refused_pushes);
    $display("registers swept through both mask and time unit extremes, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", due_reports.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/mspg_pkg.sv
rtl/mspg_axis.sv
rtl/multi_axis_step_pulse_generator.sv
bench/testbench.sv
